// ===== rtl/core/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and constants shared by the SRTF scheduler cells and control.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned TimeW  = 20;
  localparam int unsigned BurstW = 16;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ClockW = 22;
  localparam int unsigned TaW    = 21;
  localparam int unsigned SumW   = 40;
  localparam int unsigned CntW   = 16;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_STORED = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;
  localparam logic [1:0] KIND_SET    = 2'd3;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [TimeW-1:0]  arrive_time;
    logic [BurstW-1:0] burst_time;
    logic [IdxW-1:0]   proc_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] done_index;
    logic [TaW-1:0]  turnaround;
    logic [SumW-1:0] total_turnaround;
    logic [CntW-1:0] finished_count;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [BurstW-1:0] remaining;
    logic [TimeW-1:0]  arrival;
    logic [IdxW-1:0]   index;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_POP,
    OP_INSERT,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              dec;
    logic [BurstW-1:0] sub;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINAL
  } state_t;

endpackage

// ===== rtl/core/srtf_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// srtf_scheduler_unit
// Shortest-remaining-time-first scheduler over a sorted chain of slots.
// ----------------------------------------------------------------------------
// Usage: drive in_item and raise start while busy is low; the item is taken
// on that edge and busy rises. An arrival first runs stored processes up to
// its arrival time, one completion result per cycle, then gives one result
// that reports the arrival stored or dropped. A flush runs every stored
// process to completion, one per cycle, then reports the set totals and
// clears the clock, total and count.
// Results appear on out_item for one cycle with out_strobe high; last marks
// the final result of an item. The receiver cannot stall.
// While an item runs, busy stays high through its head pops, then a step that
// runs the head up to the arrival time and advances the clock (an arrival
// only), then a step that forms the final result. Each result is on the
// ports in the cycle after the one that forms it, so the final result shows
// in the first cycle with busy low. A new item is taken only once busy is low;
// the head pop sets one completion per cycle, since the sorted chain always
// holds the next process at its head. Reset empties the chain and zeroes
// clock, total and count.
module srtf_scheduler_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srtf_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output srtf_pkg::out_item_t out_item
);
  import srtf_pkg::*;

  localparam int unsigned FillW = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [ClockW-1:0] clock_r, clock_nxt;
  logic [SumW-1:0]   sum_r, sum_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [FillW-1:0]  fill_r, fill_nxt;
  logic              strobe_r, strobe_nxt;
  out_item_t         out_r, out_nxt;

  cell_ctrl_t        head_ctrl, ctrl;
  entry_t            new_entry;
  entry_t            cell_q [DEPTH];
  logic              place_q [DEPTH];

  entry_t            head;
  logic              drain;
  logic [ClockW-1:0] arr_ext, limit, diff;
  logic [ClockW:0]   fin_sum;
  logic [ClockW-1:0] clk_fin, ta_raw;
  logic [TaW-1:0]    ta;
  logic [SumW:0]     sum_add;
  logic              complete;

  assign head      = cell_q[0];
  assign drain     = (req_r.cmd == CMD_FLUSH);
  assign arr_ext   = ClockW'(req_r.arrive_time);
  assign limit     = (arr_ext < clock_r) ? clock_r : arr_ext;
  assign diff      = limit - clock_r;
  assign fin_sum   = {1'b0, clock_r} + (ClockW + 1)'(head.remaining);
  assign clk_fin   = fin_sum[ClockW] ? {ClockW{1'b1}} : fin_sum[ClockW-1:0];
  assign ta_raw    = (clk_fin >= ClockW'(head.arrival)) ?
                     clk_fin - ClockW'(head.arrival) : '0;
  assign ta        = ta_raw[ClockW-1] ? {TaW{1'b1}} : ta_raw[TaW-1:0];
  assign sum_add   = {1'b0, sum_r} + (SumW + 1)'(ta);
  assign complete  = head.valid && (drain || fin_sum <= {1'b0, limit});

  assign new_entry.valid     = 1'b1;
  assign new_entry.remaining = req_r.burst_time;
  assign new_entry.arrival   = req_r.arrive_time;
  assign new_entry.index     = req_r.proc_index;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_e, right_e;
      logic   left_p;
      if (gi == 0) begin : g_first
        assign left_e = '0;
        assign left_p = 1'b0;
      end else begin : g_mid
        assign left_e = cell_q[gi-1];
        assign left_p = place_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_end
        assign right_e = '0;
      end else begin : g_nxt
        assign right_e = cell_q[gi+1];
      end
      srtf_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        ((gi == 0) ? head_ctrl : ctrl),
        .new_entry   (new_entry),
        .left_entry  (left_e),
        .right_entry (right_e),
        .left_place  (left_p),
        .place       (place_q[gi]),
        .entry       (cell_q[gi])
      );
    end
  endgenerate

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    clock_nxt  = clock_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    fill_nxt   = fill_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    ctrl       = '{op: OP_HOLD, dec: 1'b0, sub: '0};
    head_ctrl  = '{op: OP_HOLD, dec: 1'b0, sub: '0};
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (complete) begin
          ctrl.op      = OP_POP;
          head_ctrl.op = OP_POP;
          clock_nxt    = clk_fin;
          sum_nxt      = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
          cnt_nxt      = (cnt_r == {CntW{1'b1}}) ? cnt_r : cnt_r + 1'b1;
          fill_nxt     = fill_r - 1'b1;
          strobe_nxt   = 1'b1;
          out_nxt      = '{kind: KIND_DONE, done_index: head.index, turnaround: ta,
                           total_turnaround: sum_nxt, finished_count: cnt_nxt,
                           last: 1'b0};
        end else begin
          // run the head partway up to the arrival time
          if (!drain) begin
            head_ctrl.dec = head.valid;
            head_ctrl.sub = diff[BurstW-1:0];
            clock_nxt     = limit;
          end
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        if (drain) begin
          out_nxt      = '{kind: KIND_SET, done_index: '0, turnaround: '0,
                           total_turnaround: sum_r, finished_count: cnt_r,
                           last: 1'b1};
          ctrl.op      = OP_CLEAR;
          head_ctrl.op = OP_CLEAR;
          clock_nxt    = '0;
          sum_nxt      = '0;
          cnt_nxt      = '0;
          fill_nxt     = '0;
        end else if (fill_r < FillW'(DEPTH)) begin
          ctrl.op      = OP_INSERT;
          head_ctrl.op = OP_INSERT;
          fill_nxt     = fill_r + 1'b1;
          out_nxt      = '{kind: KIND_STORED, done_index: req_r.proc_index,
                           turnaround: '0, total_turnaround: sum_r,
                           finished_count: cnt_r, last: 1'b1};
        end else begin
          out_nxt      = '{kind: KIND_DROP, done_index: req_r.proc_index,
                           turnaround: '0, total_turnaround: sum_r,
                           finished_count: cnt_r, last: 1'b1};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      clock_r  <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      fill_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clock_r  <= clock_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      strobe_r <= strobe_nxt;
    end
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== rtl/core/srtf_cell.sv =====
// ----------------------------------------------------------------------------
// srtf_cell
// One slot of the sorted process chain: holds an entry, lowers its remaining time on hold with dec set,
// shifts left on pop, shifts right or takes the new entry on insert, and empties on clear.
// ----------------------------------------------------------------------------
module srtf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  srtf_pkg::cell_ctrl_t ctrl,
  input  srtf_pkg::entry_t    new_entry,
  input  srtf_pkg::entry_t    left_entry,
  input  srtf_pkg::entry_t    right_entry,
  input  logic                left_place,
  output logic                place,
  output srtf_pkg::entry_t    entry
);
  import srtf_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BurstW-1:0] rem_r, rem_nxt;
  logic [TimeW-1:0]  arr_r, arr_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic              new_lt;

  assign new_lt = {new_entry.remaining, new_entry.arrival, new_entry.index} <
                  {rem_r, arr_r, idx_r};
  assign place  = !valid_r || new_lt;

  assign entry.valid     = valid_r;
  assign entry.remaining = rem_r;
  assign entry.arrival   = arr_r;
  assign entry.index     = idx_r;

  always_comb begin
    valid_nxt = valid_r;
    rem_nxt   = rem_r;
    arr_nxt   = arr_r;
    idx_nxt   = idx_r;
    case (ctrl.op)
      OP_HOLD: begin
        if (ctrl.dec) begin
          rem_nxt = rem_r - ctrl.sub;
        end
      end
      OP_POP: begin
        valid_nxt = right_entry.valid;
        rem_nxt   = right_entry.remaining;
        arr_nxt   = right_entry.arrival;
        idx_nxt   = right_entry.index;
      end
      OP_INSERT: begin
        // first placing cell takes the new item, the rest shift right
        if (place && !left_place) begin
          valid_nxt = 1'b1;
          rem_nxt   = new_entry.remaining;
          arr_nxt   = new_entry.arrival;
          idx_nxt   = new_entry.index;
        end else if (place) begin
          valid_nxt = left_entry.valid;
          rem_nxt   = left_entry.remaining;
          arr_nxt   = left_entry.arrival;
          idx_nxt   = left_entry.index;
        end
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    rem_r <= rem_nxt;
    arr_r <= arr_nxt;
    idx_r <= idx_nxt;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTF scheduler testbench
// Drives arrivals and flushes with random gaps and checks every result item
// against a shortest-remaining-time-first predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
import srtf_pkg::*;

class srtf_scoreboard;
  localparam int Depth = 16;
  logic [BurstW-1:0] rem_q [Depth];
  logic [TimeW-1:0]  arr_q [Depth];
  logic [IdxW-1:0]   idx_q [Depth];
  bit                vld_q [Depth];
  logic [ClockW-1:0] clk_now;
  logic [SumW-1:0]   ta_sum;
  logic [CntW-1:0]   n_done;
  out_item_t         pending[$];
  int                errors;

  function new();
    foreach (vld_q[s]) vld_q[s] = 0;
    clk_now = 0;
    ta_sum = 0;
    n_done = 0;
    errors = 0;
  endfunction

  function bit beats(int a, int b);
    if (rem_q[a] != rem_q[b]) return rem_q[a] < rem_q[b];
    if (arr_q[a] != arr_q[b]) return arr_q[a] < arr_q[b];
    if (idx_q[a] != idx_q[b]) return idx_q[a] < idx_q[b];
    return a < b;
  endfunction

  function void push(logic [1:0] kind, logic [IdxW-1:0] idx, logic [TaW-1:0] ta);
    out_item_t r;
    r.kind = kind;
    r.done_index = idx;
    r.turnaround = ta;
    r.total_turnaround = ta_sum;
    r.finished_count = n_done;
    r.last = 0;
    pending = {pending, r};
  endfunction

  function void run_to(logic [ClockW-1:0] limit, bit drain);
    int best;
    longint c, ta, sum;
    forever begin
      best = -1;
      for (int s = 0; s < Depth; s++)
        if (vld_q[s] && (best < 0 || beats(s, best))) best = s;
      if (best < 0) break;
      c = longint'(clk_now) + rem_q[best];
      if (drain || c <= limit) begin
        clk_now = (c > 64'h3FFFFF) ? 22'h3FFFFF : c[ClockW-1:0];
        ta = (clk_now >= arr_q[best]) ? clk_now - arr_q[best] : 0;
        if (ta > 64'h1FFFFF) ta = 64'h1FFFFF;
        sum = longint'(ta_sum) + ta;
        ta_sum = (sum > 64'hFF_FFFF_FFFF) ? '1 : sum[SumW-1:0];
        if (n_done != '1) n_done++;
        vld_q[best] = 0;
        push(KIND_DONE, idx_q[best], ta[TaW-1:0]);
      end else begin
        rem_q[best] = rem_q[best] - BurstW'(limit - clk_now);
        clk_now = limit;
        break;
      end
    end
    if (!drain && clk_now < limit) clk_now = limit;
  endfunction

  // Predict the result items of one accepted input item.
  function void note_item(in_item_t it);
    int free_s;
    logic [ClockW-1:0] limit;
    if (it.cmd == CMD_FLUSH) begin
      run_to(clk_now, 1);
      push(KIND_SET, '0, '0);
      foreach (vld_q[s]) vld_q[s] = 0;
      clk_now = 0;
      ta_sum = 0;
      n_done = 0;
    end else begin
      limit = (it.arrive_time < clk_now) ? clk_now : ClockW'(it.arrive_time);
      run_to(limit, 0);
      free_s = -1;
      for (int s = 0; s < Depth; s++)
        if (!vld_q[s] && free_s < 0) free_s = s;
      if (free_s >= 0) begin
        rem_q[free_s] = it.burst_time;
        arr_q[free_s] = it.arrive_time;
        idx_q[free_s] = it.proc_index;
        vld_q[free_s] = 1;
        push(KIND_STORED, it.proc_index, '0);
      end else begin
        push(KIND_DROP, it.proc_index, '0);
      end
    end
    pending[$].last = 1;
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      $display("%0t: mismatch expected kind=%0d idx=%0d ta=%0d sum=%0d cnt=%0d last=%0d",
               $time, exp_r.kind, exp_r.done_index, exp_r.turnaround,
               exp_r.total_turnaround, exp_r.finished_count, exp_r.last);
      $display("%0t:          actual   kind=%0d idx=%0d ta=%0d sum=%0d cnt=%0d last=%0d",
               $time, got.kind, got.done_index, got.turnaround,
               got.total_turnaround, got.finished_count, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  srtf_scoreboard sched_sb = new();
  int  idle_pct = 9;
  int  quiet_cycles = 0;
  logic [TimeW-1:0] t_next = 0;

  localparam int WatchLimit = 2000;

  srtf_scheduler_unit #(.DEPTH(16)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) sched_sb.note_item(in_item);
    if (rst_n && out_strobe) sched_sb.check_result(out_item);
    if ((start && !busy) || out_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Hold start high across back-to-back items; drop it only on idle cycles.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      in_item <= '{cmd: CMD_ARRIVE, arrive_time: $urandom, burst_time: $urandom,
                   proc_index: $urandom};
      @(posedge clk);
    end
    start <= 1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic arrive(logic [TimeW-1:0] t, logic [BurstW-1:0] b, logic [IdxW-1:0] i);
    send_item('{cmd: CMD_ARRIVE, arrive_time: t, burst_time: b, proc_index: i});
  endtask

  task automatic flush_set();
    send_item('{cmd: CMD_FLUSH, arrive_time: $urandom, burst_time: $urandom,
                proc_index: $urandom});
    t_next = 0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      flush_set();
    end else begin
      // mostly nondecreasing arrivals; a few go back in time
      if (r < 12) t_next = t_next - TimeW'($urandom_range(200));
      else if (r < 14) t_next = t_next + TimeW'($urandom);
      else if (r < 60) t_next = t_next + TimeW'($urandom_range(40));
      else t_next = t_next + TimeW'($urandom_range(3));
      arrive(t_next,
             ($urandom_range(9) == 0) ? BurstW'($urandom) :
             ($urandom_range(9) == 0) ? '0 : BurstW'($urandom_range(60)),
             IdxW'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero burst, ties, completion at arrival, extremes
    arrive(0, 0, 10'd1023);
    arrive(0, 5, 3);
    arrive(0, 5, 2);
    arrive(5, 5, 0);
    arrive(10, 16'hFFFF, 7);
    arrive(2, 1, 4);
    for (int k = 0; k < 12; k++) arrive(20, 100, IdxW'(k));
    arrive(20, 1, 9);
    flush_set();
    arrive(20'hFFFFF, 16'hFFFF, 10'h155);
    arrive(20'hFFFFF, 16'hFFFF, 10'h2AA);
    arrive(20'hFFFFF, 0, 0);
    flush_set();
    for (int k = 0; k < 100; k++) random_item();
    idle_pct = 51;
    for (int k = 0; k < 100; k++) random_item();
    idle_pct = 0;
    for (int k = 0; k < 85; k++) random_item();
    flush_set();
    start <= 0;
    while (sched_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sched_sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
